>>> rtl/vkt_pkg.sv
package vkt_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int RESULT_CAP  = 16;

    localparam int IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(RESULT_CAP + 1);
    localparam int MODE_W = 3;
    localparam int KEY_W  = 16;
    localparam int VER_W  = 5;
    localparam int INFO_W = 32;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 4;
    localparam int KV_W   = KEY_W + VER_W;

    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [VER_W-1:0] VERSION_MAX = VER_W'(31);

    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEL_KEY = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEL_KV  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SRCH_KEY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SRCH_KV = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_KEY_ZERO  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

>>> rtl/vkt_ram.sv
module vkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          aclk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/versioned_key_table_top.sv
// result: the final beat is registered in ST_FINISH once the slot scan ends; the scan
//   stops at the first hit in exact-match modes, and a zero key skips the scan
// one item at a time (s_tready only in ST_IDLE); scan reads one slot per cycle unless stalled
// search-by-key results: one per match, all but the last during the scan; stalls hold the scan
// reset: synchronous active-low aresetn clears control and per-slot valid flags at once,
//   so the table reads empty right after reset with no clearing pass
module versioned_key_table_top
    import vkt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // key[15:0], version[20:16], info[52:21], zero pad
    input  logic [2:0]  s_tuser,  // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // slot[3:0], found_key[19:4], found_version[24:20],
                                  // found_info[56:25], zero pad
    output logic [1:0]  m_tuser,  // status[1:0]
    output logic        m_tlast
);

    state_t state_reg, state_next;

    logic [MODE_W-1:0] op_mode_reg;
    logic [KEY_W-1:0]  op_key_reg;
    logic [VER_W-1:0]  op_ver_reg;
    logic [INFO_W-1:0] op_info_reg;

    logic [IDX_W-1:0]  p_idx_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  res_idx_reg;
    logic [KEY_W-1:0]  res_key_reg;
    logic [VER_W-1:0]  res_ver_reg;
    logic [INFO_W-1:0] res_info_reg;
    logic [VER_W-1:0]  ver_cnt_reg;
    logic              empty_vld_reg;
    logic [IDX_W-1:0]  empty_idx_reg;
    logic [CNT_W-1:0]  match_cnt_reg;
    logic [TABLE_SLOTS-1:0] valid_reg;

    logic              out_vld_reg;
    logic [STAT_W-1:0] out_stat_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic [VER_W-1:0]  out_ver_reg;
    logic [INFO_W-1:0] out_info_reg;
    logic              out_last_reg;

    logic [KV_W-1:0]   kv_rdata;
    logic [INFO_W-1:0] info_rdata;
    logic [IDX_W-1:0]  raddr;
    logic              kv_we;
    logic [IDX_W-1:0]  kv_waddr;
    logic [KV_W-1:0]   kv_wdata;
    logic              info_we;

    logic [KEY_W-1:0]  cur_key;
    logic [VER_W-1:0]  cur_ver;
    logic              key_match;
    logic              exact;
    logic              out_free;
    logic              push_mid;
    logic              stall;
    logic              advance;
    logic              done_early;
    logic              scan_end;
    logic              accept;

    logic              push;
    logic [STAT_W-1:0] push_stat;
    logic [SLOT_W-1:0] push_slot;
    logic [KEY_W-1:0]  push_key;
    logic [VER_W-1:0]  push_ver;
    logic [INFO_W-1:0] push_info;
    logic              push_last;

    logic [MODE_W-1:0] in_mode;
    logic [KEY_W-1:0]  in_key;

    assign in_mode = s_tuser;
    assign in_key  = s_tdata[15:0];

    vkt_ram #(.WIDTH(KV_W), .DEPTH(TABLE_SLOTS)) u_kv_ram (
        .aclk  (aclk),
        .we    (kv_we),
        .waddr (kv_waddr),
        .wdata (kv_wdata),
        .raddr (raddr),
        .rdata (kv_rdata)
    );

    vkt_ram #(.WIDTH(INFO_W), .DEPTH(TABLE_SLOTS)) u_info_ram (
        .aclk  (aclk),
        .we    (info_we),
        .waddr (empty_idx_reg),
        .wdata (op_info_reg),
        .raddr (raddr),
        .rdata (info_rdata)
    );

    assign cur_key   = valid_reg[p_idx_reg] ? kv_rdata[KEY_W-1:0] : '0;
    assign cur_ver   = valid_reg[p_idx_reg] ? kv_rdata[KV_W-1:KEY_W] : '0;
    assign key_match = (cur_key == op_key_reg);
    assign exact     = key_match && (cur_ver == op_ver_reg);
    assign out_free  = !out_vld_reg || m_tready;

    assign accept   = s_tvalid && s_tready;
    assign push_mid = (state_reg == ST_SCAN) && (op_mode_reg == MODE_SRCH_KEY)
                      && key_match && hit_reg;
    assign stall    = push_mid && !out_free;
    assign advance  = (state_reg == ST_SCAN) && !stall;

    always_comb begin
        case (op_mode_reg)
            MODE_DEL_KV, MODE_SRCH_KV: done_early = exact;
            MODE_SRCH_KEY: done_early = key_match && (match_cnt_reg == CNT_W'(RESULT_CAP - 1));
            default:       done_early = 1'b0;
        endcase
    end

    assign scan_end = advance && ((p_idx_reg == LAST_IDX) || done_early);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (in_mode <= MODE_SRCH_KV)) begin
                    state_next = (in_key == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory and result controls
    always_comb begin
        s_tready  = 1'b0;
        raddr     = '0;
        kv_we     = 1'b0;
        kv_waddr  = p_idx_reg;
        kv_wdata  = '0;
        info_we   = 1'b0;
        push      = 1'b0;
        push_stat = STAT_OK;
        push_slot = '0;
        push_key  = '0;
        push_ver  = '0;
        push_info = '0;
        push_last = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_SCAN: begin
                raddr = advance ? (p_idx_reg + IDX_W'(1)) : p_idx_reg;
                if (advance) begin
                    if ((op_mode_reg == MODE_DEL_KEY) && key_match) begin
                        kv_we = 1'b1;
                    end
                    if ((op_mode_reg == MODE_DEL_KV) && exact) begin
                        kv_we = 1'b1;
                    end
                end
                if (push_mid && out_free) begin
                    push      = 1'b1;
                    push_slot = SLOT_W'(res_idx_reg);
                    push_key  = res_key_reg;
                    push_ver  = res_ver_reg;
                    push_info = res_info_reg;
                    push_last = 1'b0;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    push = 1'b1;
                    if (op_key_reg == '0) begin
                        push_stat = STAT_KEY_ZERO;
                    end else if (op_mode_reg == MODE_INSERT) begin
                        if (empty_vld_reg) begin
                            kv_we     = 1'b1;
                            kv_waddr  = empty_idx_reg;
                            kv_wdata  = {ver_cnt_reg, op_key_reg};
                            info_we   = 1'b1;
                            push_slot = SLOT_W'(empty_idx_reg);
                            push_key  = op_key_reg;
                            push_ver  = ver_cnt_reg;
                            push_info = op_info_reg;
                        end else begin
                            push_stat = STAT_FULL;
                        end
                    end else if (hit_reg) begin
                        push_slot = SLOT_W'(res_idx_reg);
                        push_key  = res_key_reg;
                        push_ver  = res_ver_reg;
                        push_info = res_info_reg;
                    end else begin
                        push_stat = STAT_NOT_FOUND;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (kv_we) begin
                valid_reg[kv_waddr] <= 1'b1;
            end
            if (push) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_mode_reg   <= in_mode;
            op_key_reg    <= in_key;
            op_ver_reg    <= s_tdata[20:16];
            op_info_reg   <= s_tdata[52:21];
            p_idx_reg     <= '0;
            hit_reg       <= 1'b0;
            ver_cnt_reg   <= VER_W'(1);
            empty_vld_reg <= 1'b0;
            match_cnt_reg <= '0;
        end else if (advance) begin
            p_idx_reg <= p_idx_reg + IDX_W'(1);
            if ((cur_key == '0) && !empty_vld_reg) begin
                empty_vld_reg <= 1'b1;
                empty_idx_reg <= p_idx_reg;
            end
            if (key_match && (ver_cnt_reg != VERSION_MAX)) begin
                ver_cnt_reg <= ver_cnt_reg + VER_W'(1);
            end
            if (key_match) begin
                match_cnt_reg <= match_cnt_reg + CNT_W'(1);
            end
            case (op_mode_reg)
                MODE_DEL_KEY: begin
                    if (key_match && !hit_reg) begin
                        hit_reg      <= 1'b1;
                        res_idx_reg  <= p_idx_reg;
                        res_key_reg  <= cur_key;
                        res_ver_reg  <= cur_ver;
                        res_info_reg <= info_rdata;
                    end
                end
                MODE_DEL_KV, MODE_SRCH_KV: begin
                    if (exact) begin
                        hit_reg      <= 1'b1;
                        res_idx_reg  <= p_idx_reg;
                        res_key_reg  <= cur_key;
                        res_ver_reg  <= cur_ver;
                        res_info_reg <= info_rdata;
                    end
                end
                MODE_SRCH_KEY: begin
                    if (key_match) begin
                        hit_reg      <= 1'b1;
                        res_idx_reg  <= p_idx_reg;
                        res_key_reg  <= cur_key;
                        res_ver_reg  <= cur_ver;
                        res_info_reg <= info_rdata;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            out_stat_reg <= push_stat;
            out_slot_reg <= push_slot;
            out_key_reg  <= push_key;
            out_ver_reg  <= push_ver;
            out_info_reg <= push_info;
            out_last_reg <= push_last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'b0, out_info_reg, out_ver_reg, out_key_reg, out_slot_reg};
    assign m_tuser  = out_stat_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> test/tb_top.sv
module tb_top
    import vkt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_OPS   = 220;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * (TABLE_SLOTS + 2);
    localparam int REPORT_MAX   = 10;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [VER_W-1:0]  ver;
        logic [INFO_W-1:0] info;
    } table_op_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic [VER_W-1:0]  ver;
        logic [INFO_W-1:0] info;
        logic              last;
    } reply_t;

    class key_table_mirror;
        logic [KEY_W-1:0]  keys  [TABLE_SLOTS];
        logic [VER_W-1:0]  vers  [TABLE_SLOTS];
        logic [INFO_W-1:0] infos [TABLE_SLOTS];
        reply_t replies_due[$];
        int mismatches;
        int replies_checked;
        int full_count;
        int multi_hits;

        function new();
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                keys[i]  = '0;
                vers[i]  = '0;
                infos[i] = '0;
            end
            mismatches      = 0;
            replies_checked = 0;
            full_count      = 0;
            multi_hits      = 0;
        endfunction

        static function reply_t make_reply(logic [STAT_W-1:0] status, logic [SLOT_W-1:0] slot,
                                           logic [KEY_W-1:0] key, logic [VER_W-1:0] ver,
                                           logic [INFO_W-1:0] info, logic last);
            reply_t r;
            r.status = status;
            r.slot   = slot;
            r.key    = key;
            r.ver    = ver;
            r.info   = info;
            r.last   = last;
            return r;
        endfunction

        function void push_status(logic [STAT_W-1:0] status);
            replies_due.push_back(make_reply(status, '0, '0, '0, '0, 1'b1));
        endfunction

        function void push_slot(int s, logic last);
            replies_due.push_back(make_reply(STAT_OK, SLOT_W'(s), keys[s], vers[s], infos[s],
                                             last));
        endfunction

        function void clear_slot(int s);
            keys[s]  = '0;
            vers[s]  = '0;
            infos[s] = '0;
        endfunction

        function int exact_slot(logic [KEY_W-1:0] key, logic [VER_W-1:0] ver);
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (keys[i] == key && vers[i] == ver) return i;
            end
            return -1;
        endfunction

        function void apply_op(table_op_t op);
            int empty;
            int copies;
            int first;
            int hits[$];
            if (op.mode > MODE_SRCH_KV) return;
            if (op.key == '0) begin
                push_status(STAT_KEY_ZERO);
                return;
            end
            case (op.mode)
                MODE_INSERT: begin
                    empty  = -1;
                    copies = 1;
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        if (keys[i] == '0 && empty < 0) empty = i;
                        if (keys[i] == op.key) copies++;
                    end
                    if (empty < 0) begin
                        push_status(STAT_FULL);
                        full_count++;
                    end else begin
                        if (copies > VERSION_MAX) copies = VERSION_MAX;
                        keys[empty]  = op.key;
                        vers[empty]  = VER_W'(copies);
                        infos[empty] = op.info;
                        push_slot(empty, 1'b1);
                    end
                end
                MODE_DEL_KEY: begin
                    first = -1;
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        if (keys[i] == op.key) begin
                            if (first < 0) begin
                                first = i;
                                push_slot(i, 1'b1);
                            end
                            clear_slot(i);
                        end
                    end
                    if (first < 0) push_status(STAT_NOT_FOUND);
                end
                MODE_DEL_KV: begin
                    first = exact_slot(op.key, op.ver);
                    if (first < 0) begin
                        push_status(STAT_NOT_FOUND);
                    end else begin
                        push_slot(first, 1'b1);
                        clear_slot(first);
                    end
                end
                MODE_SRCH_KEY: begin
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        if (keys[i] == op.key && hits.size() < RESULT_CAP) hits.push_back(i);
                    end
                    if (hits.size() == 0) push_status(STAT_NOT_FOUND);
                    if (hits.size() > 1) multi_hits++;
                    foreach (hits[h]) push_slot(hits[h], h == hits.size() - 1);
                end
                default: begin
                    first = exact_slot(op.key, op.ver);
                    if (first < 0) push_status(STAT_NOT_FOUND);
                    else push_slot(first, 1'b1);
                end
            endcase
        endfunction

        function void flag(string what, reply_t want, reply_t got);
            if (mismatches < REPORT_MAX) begin
                $display("%0t %s: expected st=%0d slot=%0d key=%h ver=%0d info=%h last=%b",
                         $time, what, want.status, want.slot, want.key, want.ver, want.info,
                         want.last);
                $display("    got st=%0d slot=%0d key=%h ver=%0d info=%h last=%b",
                         got.status, got.slot, got.key, got.ver, got.info, got.last);
            end
            mismatches++;
        endfunction

        function void match_reply(reply_t got);
            reply_t want;
            if (replies_due.size() == 0) begin
                flag("unexpected beat", '0, got);
                return;
            end
            want = replies_due.pop_front();
            replies_checked++;
            if (got.status !== want.status || got.slot !== want.slot || got.key !== want.key ||
                got.ver !== want.ver || got.info !== want.info || got.last !== want.last)
                flag("beat mismatch", want, got);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    key_table_mirror mirror = new();

    int cycle_count = 0;
    int burst_left  = 0;
    int ops_sent    = 0;
    int rx_left     = 0;
    int rx_kind     = 0;
    int rx_phase    = 0;
    logic [KEY_W-1:0] key_pool [4] = '{16'h0001, 16'h8000, 16'h5a5a, 16'hffff};

    versioned_key_table_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            mirror.match_reply(key_table_mirror::make_reply(m_tuser, m_tdata[3:0],
                m_tdata[19:4], m_tdata[24:20], m_tdata[56:25], m_tlast));
    end

    // receiver stall pattern, picked anew at random from four kinds
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_left = $urandom_range(16, 96);
            rx_kind = $urandom_range(0, 3);
        end
        rx_left--;
        rx_phase++;
        case (rx_kind)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= (rx_phase % 3 != 0);
            default: m_tready <= (rx_phase % 11 < 3);
        endcase
    end

    function automatic table_op_t mk_op(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                        logic [VER_W-1:0] ver, logic [INFO_W-1:0] info);
        table_op_t op;
        op.mode = mode;
        op.key  = key;
        op.ver  = ver;
        op.info = info;
        return op;
    endfunction

    // mostly ops on a small key pool so that hits and full tables happen
    function automatic table_op_t random_op();
        table_op_t op;
        int pick;
        if ($urandom_range(0, 15) == 0)
            key_pool[$urandom_range(0, 3)] = KEY_W'($urandom_range(1, 65535));
        pick    = $urandom_range(0, 99);
        op.key  = key_pool[$urandom_range(0, 3)];
        op.ver  = VER_W'($urandom_range(1, 6));
        op.info = $urandom();
        op.mode = MODE_INSERT;
        if ($urandom_range(0, 3) == 0) op.ver = VER_W'($urandom_range(0, 31));
        if (pick < 35) op.mode = MODE_INSERT;
        else if (pick < 45) op.mode = MODE_DEL_KEY;
        else if (pick < 60) op.mode = MODE_DEL_KV;
        else if (pick < 75) op.mode = MODE_SRCH_KEY;
        else if (pick < 87) op.mode = MODE_SRCH_KV;
        else begin
            op.mode = MODE_W'($urandom_range(MODE_INSERT, MODE_SRCH_KV));
            op.ver  = VER_W'($urandom_range(0, 31));
            case ($urandom_range(0, 2))
                0: op.key = '0;
                1: op.mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
                default: op.key = KEY_W'($urandom());
            endcase
        end
        return op;
    endfunction

    task automatic send_op(input table_op_t op);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, op.info, op.ver, op.key};
        s_tuser  <= op.mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        mirror.apply_op(op);
        ops_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 9) == 0) gap = $urandom_range(10, 30);
            else gap = $urandom_range(0, 4);
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(0, 11);
        end
    endtask

    task automatic wait_for_replies();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (mirror.replies_due.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // zero key in several modes, a spare mode, search on an empty table
        send_op(mk_op(MODE_INSERT, '0, '1, '1));
        send_op(mk_op(MODE_DEL_KEY, '0, '0, '0));
        send_op(mk_op(MODE_SRCH_KV, '0, '1, '1));
        send_op(mk_op(MODE_SPARE_HI, '1, '1, '1));
        send_op(mk_op(MODE_SRCH_KEY, 16'h1234, '0, '0));

        // fill every slot with one key, then overflow
        for (int i = 0; i < TABLE_SLOTS; i++)
            send_op(mk_op(MODE_INSERT, '1, '0, (i % 2 == 0) ? '1 : INFO_W'($urandom())));
        send_op(mk_op(MODE_INSERT, 16'h0001, '0, '0));
        send_op(mk_op(MODE_SRCH_KEY, '1, '0, '0));
        send_op(mk_op(MODE_SRCH_KV, '1, VER_W'(TABLE_SLOTS), '0));
        send_op(mk_op(MODE_DEL_KV, '1, VER_W'(1), '0));
        send_op(mk_op(MODE_DEL_KEY, '1, '0, '0));
        send_op(mk_op(MODE_DEL_KEY, '1, '0, '0));
        send_op(mk_op(MODE_DEL_KV, 16'h0001, '0, '0));
        wait_for_replies();

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n == RANDOM_OPS / 2) wait_for_replies();
            send_op(random_op());
        end

        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d operations, checked %0d result beats", ops_sent,
                 mirror.replies_checked);
        $display("table-full rejects: %0d, searches with several hits: %0d",
                 mirror.full_count, mirror.multi_hits);
        if (mirror.mismatches == 0 && mirror.replies_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
